@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STOP   = 8;   // power of two: the tab phase is a mask of the offset
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // field widths
   localparam int MODE_W = 3;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd10;

   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT   = 3'd0,
      MODE_SET   = 3'd1,
      MODE_CLEAR = 3'd2,
      MODE_WRITE = 3'd3,
      MODE_READ  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_TAIL,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

@@ rtl/tcw_ram.sv @@
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/text_console_writer.sv @@
`timescale 1ns / 1ps

// channel  direction  payload
// req      in         tdata: char_code[7:0] col[14:8] row[19:15]; tuser: mode[2:0]
// rsp      out        tdata: cursor_col[6:0] cursor_row[11:7] cell_char[19:12]
//                            cell_attr[27:20] scrolled[28]
// csr      in         wr_en, wr_data: default_attribute
//
// Most transfers read or write the cell memory in the accept cycle and load the result
// into the output register from the done state once it is free. Clear fills the screen
// with blanks (one fill write a cycle); a put that scrolls shifts the rows up (one
// row-shift copy a cycle through the single write port, then the blank bottom row).
// After reset a clearing pass zeroes the screen; req_tready stays low until it ends.
// A stalled result holds in the output register.

module text_console_writer
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // char_code, col, row
   input  logic [MODE_W-1:0]     req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // cursor_col, cursor_row, cell_char,
                                              // cell_attr, scrolled
   input  logic                  csr_wr_en,
   input  logic [ATTR_W-1:0]     csr_wr_data
);

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              mv_ff, mv_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic              scr_ff, scr_in;
   logic              hit_ff, hit_in;
   logic [ATTR_W-1:0] attr_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   mode_type          req_mode;
   logic [CHAR_W-1:0] req_char;
   logic [COL_W-1:0]  req_col;
   logic [ROW_W-1:0]  req_row;
   logic              in_range;
   logic [ADDR_W-1:0] pos;
   logic              accept;
   logic              out_free;

   logic [COL_W:0]    tab_step;
   logic [COL_W:0]    tab_sum;
   logic [COL_W:0]    col_inc;
   logic [COL_W-1:0]  put_col;
   logic [ROW_W:0]    put_row;
   logic [ADDR_W-1:0] put_off;
   logic [CELL_W-1:0] blank;

   assign req_mode = mode_type'(req_tuser);
   assign req_char = req_tdata[7:0];
   assign req_col  = req_tdata[14:8];
   assign req_row  = req_tdata[19:15];
   assign in_range = (req_col < COL_W'(COLUMNS)) && (req_row < ROW_W'(ROWS));
   assign pos      = ADDR_W'(req_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_col);
   assign blank    = {attr_ff, CH_SPACE};
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // cursor advance for put char
   assign tab_step = (COL_W+1)'(TAB_STOP) - (COL_W+1)'(off_ff & ADDR_W'(TAB_STOP - 1));
   assign tab_sum  = {1'b0, col_ff} + tab_step;
   assign col_inc  = {1'b0, col_ff} + (COL_W+1)'(1);

   always_comb begin
      put_col = col_ff;
      put_row = {1'b0, row_ff};
      put_off = off_ff;
      if (req_char == CH_NEWLINE) begin
         put_col = '0;
         put_row = {1'b0, row_ff} + (ROW_W+1)'(1);
         put_off = off_ff + (ADDR_W'(COLUMNS) - ADDR_W'(col_ff));
      end else if (req_char == CH_TAB) begin
         put_off = off_ff + ADDR_W'(tab_step);
         if (tab_sum >= (COL_W+1)'(COLUMNS)) begin
            put_col = COL_W'(tab_sum - (COL_W+1)'(COLUMNS));
            put_row = {1'b0, row_ff} + (ROW_W+1)'(1);
         end else begin
            put_col = COL_W'(tab_sum);
         end
      end else begin
         put_off = off_ff + ADDR_W'(1);
         if (col_inc == (COL_W+1)'(COLUMNS)) begin
            put_col = '0;
            put_row = {1'b0, row_ff} + (ROW_W+1)'(1);
         end else begin
            put_col = COL_W'(col_inc);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wr_addr_in   = wr_addr_ff;
      mv_in        = 1'b0;
      col_in       = col_ff;
      row_in       = row_ff;
      off_in       = off_ff;
      scr_in       = scr_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = blank;
      ram_re       = 1'b0;
      ram_raddr    = cnt_ff;

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            cnt_in    = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               scr_in   = 1'b0;
               hit_in   = 1'b0;
               state_in = ST_DONE;
               case (req_mode)
                  MODE_PUT: begin
                     if (req_char != CH_NEWLINE && req_char != CH_TAB) begin
                        ram_we    = 1'b1;
                        ram_waddr = off_ff;
                        ram_wdata = {attr_ff, req_char};
                     end
                     if (put_row == (ROW_W+1)'(ROWS)) begin
                        // past the last cell: shift rows up
                        col_in   = '0;
                        row_in   = ROW_W'(ROWS - 1);
                        off_in   = ADDR_W'(CELL_COUNT - COLUMNS);
                        scr_in   = 1'b1;
                        cnt_in   = ADDR_W'(COLUMNS);
                        state_in = ST_SCROLL;
                     end else begin
                        col_in = put_col;
                        row_in = ROW_W'(put_row);
                        off_in = put_off;
                     end
                  end
                  MODE_SET: begin
                     if (in_range) begin
                        col_in = req_col;
                        row_in = req_row;
                        off_in = pos;
                     end
                  end
                  MODE_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     off_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  MODE_WRITE: begin
                     if (in_range) begin
                        ram_we    = 1'b1;
                        ram_waddr = pos;
                        ram_wdata = {attr_ff, req_char};
                     end
                  end
                  MODE_READ: begin
                     if (in_range) begin
                        ram_re    = 1'b1;
                        ram_raddr = pos;
                        hit_in    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // read a row ahead, write the previous read one row up
            ram_re     = 1'b1;
            ram_raddr  = cnt_ff;
            ram_we     = mv_ff;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            mv_in      = 1'b1;
            wr_addr_in = cnt_ff - ADDR_W'(COLUMNS);
            cnt_in     = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_ff;
            ram_wdata = ram_rdata;
            cnt_in    = ADDR_W'(CELL_COUNT - COLUMNS);
            state_in  = ST_FILL;
         end
         ST_FILL: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, scr_ff,
                               hit_ff ? ram_rdata : {CELL_W{1'b0}},
                               row_ff, col_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         mv_ff        <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         off_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mv_ff        <= mv_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      scr_ff      <= scr_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ bench/console_checker.sv @@
`timescale 1ns / 1ps

module console_checker
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // char_code, col, row
   input  logic [MODE_W-1:0]     req_tuser,   // mode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // cursor_col, cursor_row, cell_char,
                                              // cell_attr, scrolled
   input  logic                  csr_wr_en,
   input  logic [ATTR_W-1:0]     csr_wr_data,
   output int                    mismatches,
   output int                    awaited
);

   typedef struct packed {
      logic [RSP_DATA_W-30:0] pad;
      logic                   scrolled;
      logic [ATTR_W-1:0]      cell_attr;
      logic [CHAR_W-1:0]      cell_char;
      logic [ROW_W-1:0]       cursor_row;
      logic [COL_W-1:0]       cursor_col;
   } console_word_type;

   logic [CELL_W-1:0] screen [CELL_COUNT];
   int                cursor_pos;
   logic [ATTR_W-1:0] attribute;
   console_word_type  awaited_results [$];
   int                mismatch_count = 0;
   int                result_count = 0;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100)
         $display("[%0t] result %0d: %s", $realtime, result_count, what);
      mismatch_count++;
   endtask

   // Advance the screen copy by one request and queue the result it should give.
   task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                                input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      console_word_type want;
      bit               in_range;
      int               pos;
      want = '0;
      in_range = (int'(col) < COLUMNS) && (int'(row) < ROWS);
      pos = int'(row) * COLUMNS + int'(col);
      case (mode)
         MODE_PUT: begin
            if (ch == CH_NEWLINE)
               cursor_pos += COLUMNS - (cursor_pos % COLUMNS);
            else if (ch == CH_TAB)
               cursor_pos += TAB_STOP - (cursor_pos % TAB_STOP);
            else begin
               screen[cursor_pos] = {attribute, ch};
               cursor_pos++;
            end
            if (cursor_pos >= CELL_COUNT) begin
               // shift rows up one, blank the bottom row
               for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
                  screen[i] = screen[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  screen[i] = {attribute, CH_SPACE};
               cursor_pos = CELL_COUNT - COLUMNS;
               want.scrolled = 1'b1;
            end
         end
         MODE_SET: begin
            if (in_range)
               cursor_pos = pos;
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++)
               screen[i] = {attribute, CH_SPACE};
            cursor_pos = 0;
         end
         MODE_WRITE: begin
            if (in_range)
               screen[pos] = {attribute, ch};
         end
         MODE_READ: begin
            if (in_range) begin
               want.cell_char = screen[pos][CHAR_W-1:0];
               want.cell_attr = screen[pos][CELL_W-1:CHAR_W];
            end
         end
         default: begin
         end
      endcase
      want.cursor_col = COL_W'(cursor_pos % COLUMNS);
      want.cursor_row = ROW_W'(cursor_pos / COLUMNS);
      awaited_results.push_back(want);
   endtask

   always @(posedge clock) begin
      console_word_type got;
      console_word_type want;
      if (reset) begin
         foreach (screen[i])
            screen[i] = '0;
         cursor_pos = 0;
         attribute = ATTR_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en)
            attribute = csr_wr_data;
         // queue the request first: a result never belongs to a transfer on the same edge
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata[CHAR_W-1:0], req_tdata[CHAR_W+COL_W-1:CHAR_W],
                          req_tdata[CHAR_W+COL_W+ROW_W-1:CHAR_W+COL_W]);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_results.size() == 0)
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            else begin
               want = awaited_results.pop_front();
               if (got.cursor_col !== want.cursor_col)
                  report_mismatch($sformatf("cursor_col %0d, want %0d",
                                            got.cursor_col, want.cursor_col));
               if (got.cursor_row !== want.cursor_row)
                  report_mismatch($sformatf("cursor_row %0d, want %0d",
                                            got.cursor_row, want.cursor_row));
               if (got.cell_char !== want.cell_char)
                  report_mismatch($sformatf("cell_char %h, want %h",
                                            got.cell_char, want.cell_char));
               if (got.cell_attr !== want.cell_attr)
                  report_mismatch($sformatf("cell_attr %h, want %h",
                                            got.cell_attr, want.cell_attr));
               if (got.scrolled !== want.scrolled)
                  report_mismatch($sformatf("scrolled %b, want %b",
                                            got.scrolled, want.scrolled));
               if (got.pad !== want.pad)
                  report_mismatch($sformatf("padding bits %b, want zero", got.pad));
            end
            result_count++;
         end
      end
      awaited <= awaited_results.size();
      mismatches <= mismatch_count;
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 170;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [ATTR_W-1:0]     csr_wr_data = '0;

   int mismatches;
   int awaited;
   int idle_cycles = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   text_console_writer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   console_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .awaited     (awaited)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0)
            stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W - ROW_W - COL_W - CHAR_W){1'b0}}, row, col, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   // write only once every result is back
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [MODE_W-1:0] mode;
      logic [CHAR_W-1:0] ch;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  last_col;
      logic [ROW_W-1:0]  last_row;
      int                pick;
      last_col = '0;
      last_row = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset attribute
      send_request(MODE_READ, 8'h00, 7'd0, 5'd0);
      send_request(MODE_PUT, 8'h41, 7'd0, 5'd0);
      send_request(MODE_PUT, 8'h00, 7'd0, 5'd0);
      send_request(MODE_PUT, 8'hFF, 7'd0, 5'd0);
      send_request(MODE_PUT, CH_TAB, 7'd0, 5'd0);
      send_request(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0);
      send_request(MODE_READ, 8'h00, 7'd0, 5'd0);
      send_request(MODE_READ, 8'h00, 7'd2, 5'd0);
      send_request(MODE_WRITE, 8'hFF, 7'd79, 5'd24);
      send_request(MODE_READ, 8'h00, 7'd79, 5'd24);
      send_request(MODE_WRITE, 8'h55, 7'd80, 5'd0);
      send_request(MODE_WRITE, 8'hAA, 7'd127, 5'd31);
      send_request(MODE_READ, 8'hFF, 7'd127, 5'd31);
      send_request(MODE_SET, 8'h00, 7'd80, 5'd5);
      send_request(MODE_SET, 8'h00, 7'd5, 5'd25);
      // last cell, then one character past it
      send_request(MODE_SET, 8'h00, 7'd79, 5'd24);
      send_request(MODE_PUT, 8'h5A, 7'd0, 5'd0);
      send_request(MODE_READ, 8'h00, 7'd79, 5'd23);
      send_request(MODE_READ, 8'h00, 7'd0, 5'd24);
      // tab and newline off the bottom row
      send_request(MODE_SET, 8'h00, 7'd75, 5'd24);
      send_request(MODE_PUT, CH_TAB, 7'd0, 5'd0);
      send_request(MODE_SET, 8'h00, 7'd10, 5'd24);
      send_request(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0);
      send_request(MODE_W'(5), 8'hFF, 7'd127, 5'd31);
      send_request(MODE_W'(6), 8'h00, 7'd0, 5'd0);
      send_request(MODE_W'(7), 8'h33, 7'd40, 5'd12);
      send_request(MODE_CLEAR, 8'hFF, 7'd127, 5'd31);
      send_request(MODE_READ, 8'h00, 7'd40, 5'd12);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_attribute('0);
            1: write_attribute('1);
            default: write_attribute(ATTR_W'($urandom));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 64 == 0)
               quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            ch   = CHAR_W'($urandom);
            col  = COL_W'($urandom_range(0, COLUMNS - 1));
            row  = ROW_W'($urandom_range(0, ROWS - 1));
            if (pick < 42) begin
               mode = MODE_PUT;
               case ($urandom_range(0, 9))
                  0: ch = CH_NEWLINE;
                  1: ch = CH_TAB;
                  default: begin
                  end
               endcase
            end else if (pick < 56) begin
               mode = MODE_SET;
               // steer toward the bottom row so puts run off the screen
               if ($urandom_range(0, 2) == 0)
                  row = ROW_W'(ROWS - 1);
            end else if (pick < 70) begin
               mode = MODE_WRITE;
            end else if (pick < 90) begin
               mode = MODE_READ;
               if ($urandom_range(0, 1) == 0) begin
                  col = last_col;
                  row = last_row;
               end
            end else if (pick < 92) begin
               mode = MODE_CLEAR;
            end else if (pick < 95) begin
               mode = MODE_W'($urandom_range(5, 7));
            end else begin
               case ($urandom_range(0, 2))
                  0: mode = MODE_SET;
                  1: mode = MODE_WRITE;
                  default: mode = MODE_READ;
               endcase
               col = COL_W'($urandom_range(0, 127));
               row = ROW_W'($urandom_range(0, 31));
            end
            if (mode == MODE_WRITE) begin
               last_col = col;
               last_row = row;
            end
            send_request(mode, ch, col, row);
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
bench/console_checker.sv
bench/testbench.sv
